// ===== src/sabtb_pkg.sv =====
// sabtb_pkg: shared constants, item and row types for the set-associative btb
// no dependencies; imported by the interfaces and every module of the block
`timescale 1ns / 1ps
`default_nettype none

package sabtb_pkg;

  // geometry
  localparam int SETS     = 64;
  localparam int WAYS     = 4;
  localparam int ADDR_W   = 32;
  localparam int TGT_W    = 32;
  localparam int TAG_MAX  = 26;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] TAG_WIDTH_RESET = CFG_W'(20);
  localparam logic [CFG_W-1:0] TAG_WIDTH_MAX   = CFG_W'(TAG_MAX);

  // floor(log2(SETS)) address bits pick the set
  localparam int IDX_BITS = $clog2(SETS + 1) - 1;
  localparam int SET_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int ROWS     = 1 << IDX_BITS;

  localparam int AGE_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_W    = AGE_W;
  localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WAYS - 1);

  // front to back queue
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // classified item as the back part sees it
  typedef struct packed {
    logic               op;
    logic [SET_W-1:0]   set_idx;
    logic [TAG_MAX-1:0] tag;
    logic [TGT_W-1:0]   target;
  } req_t;

  // one set of the buffer, stored as a single memory row
  typedef struct packed {
    logic [WAYS-1:0]              vld;
    logic [WAYS-1:0][AGE_W-1:0]   age;
    logic [WAYS-1:0][TAG_MAX-1:0] tag;
    logic [WAYS-1:0][TGT_W-1:0]   tgt;
  } row_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

endpackage

`default_nettype wire

// ===== src/sabtb_in_if.sv =====
// sabtb_in_if: valid/ready channel carrying one btb request item
// depends on sabtb_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface sabtb_in_if import sabtb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] addr;
  logic [TGT_W-1:0]  target;

  modport source (output valid, output op, output addr, output target, input ready);
  modport sink   (input valid, input op, input addr, input target, output ready);
endinterface

`default_nettype wire

// ===== src/sabtb_out_if.sv =====
// sabtb_out_if: valid/ready channel carrying one btb result item
// depends on sabtb_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface sabtb_out_if import sabtb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [TGT_W-1:0] target_out;

  modport source (output valid, output hit, output target_out, input ready);
  modport sink   (input valid, input hit, input target_out, output ready);
endinterface

`default_nettype wire

// ===== src/sabtb_front.sv =====
// sabtb_front: accepts request items, holds tag_width, splits address into set and tag
// depends on sabtb_pkg and sabtb_in_if
`timescale 1ns / 1ps
`default_nettype none

module sabtb_front import sabtb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data,
  sabtb_in_if.sink              in_ch,
  input  wire logic             q_full,
  output logic                  push,
  output req_t                  push_req
);

  logic [CFG_W-1:0]   tag_width_r;
  logic [CFG_W-1:0]   tag_width_nxt;
  logic [CFG_W-1:0]   tw_eff;
  logic [ADDR_W-1:0]  addr_hi;
  logic [TAG_MAX-1:0] tag_mask;

  always_comb begin
    tag_width_nxt = cfg_we ? cfg_data : tag_width_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_width_r <= TAG_WIDTH_RESET;
    end else begin
      tag_width_r <= tag_width_nxt;
    end
  end

  // widths above the tag store clamp to it
  assign tw_eff   = (tag_width_r > TAG_WIDTH_MAX) ? TAG_WIDTH_MAX : tag_width_r;
  assign tag_mask = ~({TAG_MAX{1'b1}} << tw_eff);
  assign addr_hi  = in_ch.addr >> IDX_BITS;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_req.op      = in_ch.op;
    push_req.set_idx = (IDX_BITS > 0) ? in_ch.addr[SET_W-1:0] : '0;
    push_req.tag     = addr_hi[TAG_MAX-1:0] & tag_mask;
    push_req.target  = in_ch.target;
  end

endmodule

`default_nettype wire

// ===== src/sabtb_queue.sv =====
// sabtb_queue: short fifo of classified items between front and back
// depends on sabtb_pkg
`timescale 1ns / 1ps
`default_nettype none

module sabtb_queue import sabtb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  req_t      push_req,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output req_t      head_req
);

  req_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_req   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

`default_nettype wire

// ===== src/sabtb_back.sv =====
// sabtb_back: set row memory, hit detection, lru update and result register
// depends on sabtb_pkg and sabtb_out_if
`timescale 1ns / 1ps
`default_nettype none

module sabtb_back import sabtb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  req_t      q_head,
  output logic      q_pop,
  sabtb_out_if.source out_ch
);

  back_state_t      state_r, state_nxt;
  req_t             cur_r;
  row_t             mem [ROWS];
  row_t             rd_row_r;
  logic             row_live_r;
  logic [ROWS-1:0]  touched_r, touched_nxt;
  logic             exec;

  row_t             eff;
  row_t             new_row;
  logic             hit_any;
  logic [WAY_W-1:0] hit_way;
  logic             vic_found;
  logic [WAY_W-1:0] victim;
  logic [AGE_W-1:0] best;
  logic [AGE_W-1:0] hit_age;

  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r;
  logic [TGT_W-1:0] out_tgt_r;

  // sequencer: pop and read the row, then resolve and write it back
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    exec      = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (!out_valid_r || out_ch.ready) begin
          exec      = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // an untouched row reads as all invalid with every age at the oldest value
  always_comb begin
    eff = rd_row_r;
    if (!row_live_r) begin
      eff.vld = '0;
      for (int w = 0; w < WAYS; w++) begin
        eff.age[w] = AGE_OLDEST;
      end
    end
  end

  // first matching valid way
  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (eff.vld[w] && (eff.tag[w] == cur_r.tag)) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    hit_age = eff.age[hit_way];
  end

  // victim: first oldest way, else first way with the largest age
  always_comb begin
    vic_found = 1'b0;
    victim    = '0;
    best      = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (eff.age[w] == AGE_OLDEST) begin
        vic_found = 1'b1;
        victim    = WAY_W'(w);
      end
    end
    if (!vic_found) begin
      for (int w = 0; w < WAYS; w++) begin
        if (eff.age[w] > best) begin
          best   = eff.age[w];
          victim = WAY_W'(w);
        end
      end
    end
  end

  // row after the item
  always_comb begin
    new_row = eff;
    if (hit_any) begin
      for (int w = 0; w < WAYS; w++) begin
        if (eff.age[w] < hit_age) begin
          new_row.age[w] = eff.age[w] + 1'b1;
        end
      end
      new_row.age[hit_way] = '0;
      if (cur_r.op == OP_UPDATE) begin
        new_row.tgt[hit_way] = cur_r.target;
      end
    end else if (cur_r.op == OP_UPDATE) begin
      for (int w = 0; w < WAYS; w++) begin
        if (eff.age[w] < AGE_OLDEST) begin
          new_row.age[w] = eff.age[w] + 1'b1;
        end
      end
      new_row.age[victim] = '0;
      new_row.tag[victim] = cur_r.tag;
      new_row.tgt[victim] = cur_r.target;
      new_row.vld[victim] = 1'b1;
    end
  end

  always_comb begin
    touched_nxt = touched_r;
    if (exec) begin
      touched_nxt[cur_r.set_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touched_r <= '0;
    end else begin
      touched_r <= touched_nxt;
    end
  end

  // row memory: one read and one write port, read data registered
  always_ff @(posedge clk) begin
    if (exec) begin
      mem[cur_r.set_idx] <= new_row;
    end
    if (q_pop) begin
      rd_row_r   <= mem[q_head.set_idx];
      row_live_r <= touched_r[q_head.set_idx];
      cur_r      <= q_head;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_hit_r <= hit_any;
      out_tgt_r <= (hit_any && (cur_r.op == OP_LOOKUP)) ? eff.tgt[hit_way] : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.target_out = out_tgt_r;

endmodule

`default_nettype wire

// ===== src/set_assoc_btb_lru_unit.sv =====
// set_assoc_btb_lru_unit: set-associative branch target buffer with true lru ages
// path: an accepted item passes the queue, the registered row read and the result register
// pacing: a new item waits until the last is written back, set by the read-then-write
//   of a set row in the single row memory of the back part
// reset: control, tag_width (20) and the per-set row flags clear at once; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_btb_lru_unit import sabtb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // configuration: tag_width
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data,
  // request and result channels
  sabtb_in_if.sink              in_ch,
  sabtb_out_if.source           out_ch
);

  // front to queue
  logic push;
  req_t push_req;
  logic q_full;

  // queue to back
  logic q_valid;
  logic q_pop;
  req_t q_head;

  // front: config register, address split into set index and masked tag
  sabtb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_req (push_req)
  );

  // decoupling queue so the front keeps taking items while the back works, until it is full
  sabtb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_req   (push_req),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_req   (q_head)
  );

  // back: row memory, hit and victim selection, age update, result register
  sabtb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
